// ===== sv/kma_pkg.sv =====
// Package for the keyboard matrix auto-typer: opcodes, phase codes, key
// command type and the character decode ROM. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package kma_pkg;

  localparam int unsigned DELAY_W = 18;
  localparam logic [DELAY_W-1:0] TYPE_DELAY_RESET = 18'd200000;
  localparam logic [7:0] ALL_RELEASED = 8'hFF;
  localparam logic [5:0] SHIFT_KEY = 6'd15;

  typedef enum logic [1:0] {
    OP_KEY    = 2'd0,
    OP_COLUMN = 2'd1,
    OP_TYPE   = 2'd2,
    OP_TICK   = 2'd3
  } kma_op_e;

  localparam logic [1:0] PH_PRESS   = 2'd0;
  localparam logic [1:0] PH_RELEASE = 2'd1;
  localparam logic [1:0] PH_CLEAR   = 2'd2;

  typedef struct packed {
    logic       clear_all;
    logic       key_en;
    logic [5:0] key;
    logic       shift_en;
    logic       down;
  } kma_key_cmd_t;

  typedef struct packed {
    logic       known;
    logic       shift;
    logic [5:0] key;
  } kma_rom_t;

  localparam logic [5:0] LETTER_KEYS [26] = '{
    6'd10, 6'd28, 6'd20, 6'd18, 6'd14, 6'd21, 6'd26, 6'd29, 6'd33, 6'd34, 6'd37, 6'd42, 6'd36,
    6'd39, 6'd38, 6'd41, 6'd62, 6'd17, 6'd13, 6'd22, 6'd30, 6'd31, 6'd9, 6'd23, 6'd25, 6'd12
  };

  localparam logic [5:0] DIGIT_KEYS [10] = '{
    6'd35, 6'd56, 6'd59, 6'd8, 6'd11, 6'd16, 6'd19, 6'd24, 6'd27, 6'd32
  };

  function automatic kma_rom_t char_rom(input logic [7:0] c);
    kma_rom_t r;
    r = '0;
    if (c >= 8'h61 && c <= 8'h7a) begin
      r = '{1'b1, 1'b0, LETTER_KEYS[5'(c - 8'h61)]};
    end else if (c >= 8'h41 && c <= 8'h5a) begin
      r = '{1'b1, 1'b1, LETTER_KEYS[5'(c - 8'h41)]};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r = '{1'b1, 1'b0, DIGIT_KEYS[4'(c - 8'h30)]};
    end else begin
      case (c) inside
        8'h0a, 8'h0d: r = '{1'b1, 1'b0, 6'd1};
        8'h09, 8'h20: r = '{1'b1, 1'b0, 6'd60};
        8'h5c, 8'h5f: r = '{1'b1, 1'b0, 6'd57};
        8'h5e: r = '{1'b1, 1'b0, 6'd54};
        8'h21: r = '{1'b1, 1'b1, 6'd56};
        8'h22: r = '{1'b1, 1'b1, 6'd59};
        8'h23: r = '{1'b1, 1'b1, 6'd8};
        8'h24: r = '{1'b1, 1'b1, 6'd11};
        8'h25: r = '{1'b1, 1'b1, 6'd16};
        8'h26: r = '{1'b1, 1'b1, 6'd19};
        8'h27: r = '{1'b1, 1'b1, 6'd24};
        8'h28: r = '{1'b1, 1'b1, 6'd27};
        8'h29: r = '{1'b1, 1'b1, 6'd32};
        8'h2a: r = '{1'b1, 1'b0, 6'd49};
        8'h2b: r = '{1'b1, 1'b0, 6'd40};
        8'h2c: r = '{1'b1, 1'b0, 6'd47};
        8'h2d: r = '{1'b1, 1'b0, 6'd43};
        8'h2e: r = '{1'b1, 1'b0, 6'd44};
        8'h2f: r = '{1'b1, 1'b0, 6'd55};
        8'h3a: r = '{1'b1, 1'b0, 6'd45};
        8'h3b: r = '{1'b1, 1'b0, 6'd50};
        8'h3c: r = '{1'b1, 1'b1, 6'd47};
        8'h3d: r = '{1'b1, 1'b0, 6'd53};
        8'h3e: r = '{1'b1, 1'b1, 6'd44};
        8'h3f: r = '{1'b1, 1'b1, 6'd55};
        8'h40: r = '{1'b1, 1'b0, 6'd46};
        8'h5b: r = '{1'b1, 1'b1, 6'd45};
        8'h5d: r = '{1'b1, 1'b1, 6'd50};
        default: r = '0;
      endcase
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/kma_if.sv =====
// Valid/ready channel interfaces for the keyboard matrix auto-typer.
// Request beats carry one operation, result beats one row/count report.
`timescale 1ns / 1ps
`default_nettype none

interface kma_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [2:0]  key_column;
  logic [2:0]  key_row;
  logic        key_down;
  logic        with_shift;
  logic [7:0]  column_select;
  logic [7:0]  char_code;
  logic [63:0] tick_cycles;

  modport source (
    output valid, op, key_column, key_row, key_down, with_shift,
           column_select, char_code, tick_cycles,
    input  ready
  );
  modport sink (
    input  valid, op, key_column, key_row, key_down, with_shift,
           column_select, char_code, tick_cycles,
    output ready
  );
endinterface

interface kma_out_if #(
  parameter int unsigned COUNT_W = 7
);
  logic               valid;
  logic               ready;
  logic [7:0]         row_value;
  logic [COUNT_W-1:0] queue_count;
  logic               accepted;

  modport source (output valid, row_value, queue_count, accepted, input ready);
  modport sink (input valid, row_value, queue_count, accepted, output ready);
endinterface

`default_nettype wire

// ===== sv/kma_fifo_mem.sv =====
// Character queue storage: one write port and one registered read port.
// A read of the address being written returns the new data. No package use.
`timescale 1ns / 1ps
`default_nettype none

module kma_fifo_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [7:0]    wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [7:0]    rdata_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i && waddr_i == raddr_i) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== sv/kma_key_matrix.sv =====
// Key matrix state, eight active-low columns, and the row read-back of the
// state after the current update. Depends on kma_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kma_key_matrix (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire kma_pkg::kma_key_cmd_t cmd_i,
  input  wire logic [7:0]            column_latch_i,
  output logic      [7:0]            rows_o
);
  import kma_pkg::*;

  logic [7:0] matrix_q [8];
  logic [7:0] matrix_d [8];

  always_comb begin
    for (int c = 0; c < 8; c++) begin
      matrix_d[c] = matrix_q[c];
      if (cmd_i.clear_all) begin
        matrix_d[c] = ALL_RELEASED;
      end else begin
        if (cmd_i.key_en && cmd_i.key[5:3] == 3'(c)) begin
          matrix_d[c][cmd_i.key[2:0]] = !cmd_i.down;
        end
        if (cmd_i.shift_en && SHIFT_KEY[5:3] == 3'(c)) begin
          matrix_d[c][SHIFT_KEY[2:0]] = !cmd_i.down;
        end
      end
    end
  end

  always_comb begin
    rows_o = ALL_RELEASED;
    for (int c = 0; c < 8; c++) begin
      if (!column_latch_i[c]) begin
        rows_o = rows_o & matrix_d[c];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < 8; c++) begin
        matrix_q[c] <= ALL_RELEASED;
      end
    end else begin
      for (int c = 0; c < 8; c++) begin
        matrix_q[c] <= matrix_d[c];
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/kma_out_skid.sv =====
// Result output register with a one-beat skid stage, so that the request
// side never waits on the same-cycle result ready. No package use.
`timescale 1ns / 1ps
`default_nettype none

module kma_out_skid #(
  parameter int unsigned WIDTH = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [WIDTH-1:0] in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic      [WIDTH-1:0] out_data_o
);

  logic             out_valid_q;
  logic             skid_valid_q;
  logic [WIDTH-1:0] out_data_q;
  logic [WIDTH-1:0] skid_data_q;
  logic             in_fire;

  assign in_ready_o  = !skid_valid_q;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_ready_i || !out_valid_q) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready_i || !out_valid_q) begin
      if (skid_valid_q) begin
        out_data_q <= skid_data_q;
      end else if (in_fire) begin
        out_data_q <= in_data_i;
      end
    end else if (in_fire) begin
      skid_data_q <= in_data_i;
    end
  end

  a_skid_needs_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid beat held without a beat in the output register");

  a_skid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && !out_ready_i) |=> (skid_valid_q && $stable(skid_data_q)))
    else $error("skid beat lost while the output stalls");

  a_stall_to_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && out_valid_q && !out_ready_i) |=> skid_valid_q)
    else $error("beat accepted during a stall did not reach the skid stage");

endmodule

`default_nettype wire

// ===== sv/keyboard_matrix_autotyper.sv =====
// Keyboard matrix emulation with an auto-typing character queue.
// Top level; depends on kma_pkg, kma_if, kma_fifo_mem, kma_key_matrix, kma_out_skid.
//
// Usage: each request beat on in_i carries one operation: a key event, a new
// column select, a character to type, or a tick that advances the typer by a
// number of elapsed cycles. Every request produces exactly one result beat on
// out_o with the row value seen on the selected columns, the queue fill and
// an accepted flag that is low only when a typed character was dropped
// because the queue was full. type_delay is written through cfg_we_i and
// cfg_data_i while the block is idle; the user must keep to this, as the
// block does not enforce it. Throughput is one request per cycle while out_o
// does not stall; the state update for a request is done in its accept cycle.
// The queue head character is prefetched from the queue memory, whose read
// port follows the next head. Results are registered in the output register;
// when out_o stalls, one more request is taken into a skid stage and
// in_i.ready then drops until the stall clears. Reset releases all keys,
// deselects all columns, empties the queue and loads the default delay.
`timescale 1ns / 1ps
`default_nettype none

module keyboard_matrix_autotyper #(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  kma_in_if.sink                             in_i,
  kma_out_if.source                          out_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [kma_pkg::DELAY_W-1:0]   cfg_data_i
);
  import kma_pkg::*;

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned QCOUNT_W = 7;
  localparam int unsigned RES_W = 8 + QCOUNT_W + 1;
  localparam logic [AW:0] DEPTH_EXT = (AW + 1)'(QUEUE_DEPTH);
  localparam logic [AW-1:0] HEAD_LAST = AW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] COUNT_FULL = CW'(QUEUE_DEPTH);

  logic [DELAY_W-1:0] type_delay_q;
  logic [7:0]         column_latch_q, column_latch_d;
  logic [AW-1:0]      head_q, head_d;
  logic [CW-1:0]      count_q, count_d;
  logic [1:0]         phase_q, phase_d;
  logic [DELAY_W-1:0] pace_q, pace_d;

  logic               in_fire;
  logic               skid_ready;
  logic [AW:0]        tail_sum;
  logic [AW-1:0]      tail;
  logic               fifo_we;
  logic [7:0]         head_char;
  kma_rom_t           rom;
  kma_key_cmd_t       key_cmd;
  logic [7:0]         rows;
  logic               accepted;
  logic               timer_running;
  logic [RES_W-1:0]   res_data;

  assign in_i.ready = skid_ready;
  assign in_fire    = in_i.valid && skid_ready;

  assign tail_sum = (AW + 1)'(head_q) + (AW + 1)'(count_q);
  assign tail     = (tail_sum >= DEPTH_EXT) ? AW'(tail_sum - DEPTH_EXT) : tail_sum[AW-1:0];

  assign rom = char_rom(head_char);
  assign timer_running = (in_i.tick_cycles[63:DELAY_W] == '0) &&
                         (pace_q > in_i.tick_cycles[DELAY_W-1:0]);

  always_comb begin
    column_latch_d = column_latch_q;
    head_d         = head_q;
    count_d        = count_q;
    phase_d        = phase_q;
    pace_d         = pace_q;
    key_cmd        = '0;
    fifo_we        = 1'b0;
    accepted       = 1'b1;
    if (in_fire) begin
      unique case (kma_op_e'(in_i.op))
        OP_KEY: begin
          key_cmd.key_en   = 1'b1;
          key_cmd.key      = {in_i.key_column, in_i.key_row};
          key_cmd.shift_en = in_i.with_shift;
          key_cmd.down     = in_i.key_down;
        end
        OP_COLUMN: begin
          column_latch_d = in_i.column_select;
        end
        OP_TYPE: begin
          if (count_q == COUNT_FULL) begin
            accepted = 1'b0;
          end else begin
            fifo_we = 1'b1;
            count_d = count_q + 1'b1;
          end
        end
        OP_TICK: begin
          if (count_q != '0) begin
            if (timer_running) begin
              pace_d = pace_q - in_i.tick_cycles[DELAY_W-1:0];
            end else begin
              pace_d = type_delay_q;
              if (phase_q == PH_PRESS || phase_q == PH_RELEASE) begin
                key_cmd.key_en   = rom.known;
                key_cmd.key      = rom.key;
                key_cmd.shift_en = rom.known && rom.shift;
                key_cmd.down     = (phase_q == PH_PRESS);
                phase_d          = phase_q + 1'b1;
              end else begin
                key_cmd.clear_all = 1'b1;
                head_d  = (head_q == HEAD_LAST) ? '0 : head_q + 1'b1;
                count_d = count_q - 1'b1;
                phase_d = PH_PRESS;
              end
            end
          end
        end
        default: begin
          column_latch_d = column_latch_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      type_delay_q   <= TYPE_DELAY_RESET;
      column_latch_q <= ALL_RELEASED;
      head_q         <= '0;
      count_q        <= '0;
      phase_q        <= PH_PRESS;
      pace_q         <= '0;
    end else begin
      if (cfg_we_i) begin
        type_delay_q <= cfg_data_i;
      end
      column_latch_q <= column_latch_d;
      head_q         <= head_d;
      count_q        <= count_d;
      phase_q        <= phase_d;
      pace_q         <= pace_d;
    end
  end

  kma_fifo_mem #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (AW)
  ) u_fifo_mem (
    .clk_i   (clk_i),
    .we_i    (fifo_we),
    .waddr_i (tail),
    .wdata_i (in_i.char_code),
    .raddr_i (head_d),
    .rdata_o (head_char)
  );

  kma_key_matrix u_key_matrix (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (key_cmd),
    .column_latch_i (column_latch_d),
    .rows_o         (rows)
  );

  assign res_data = {rows, QCOUNT_W'(count_d), accepted};

  kma_out_skid #(
    .WIDTH (RES_W)
  ) u_out_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (skid_ready),
    .in_data_i   (res_data),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_data_o  ({out_o.row_value, out_o.queue_count, out_o.accepted})
  );

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= COUNT_FULL)
    else $error("queue fill beyond its depth");

  a_empty_press_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (phase_q == PH_PRESS))
    else $error("empty queue with a character still in play");

  a_drop_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !accepted) |-> (count_q == COUNT_FULL && count_d == count_q))
    else $error("character dropped while the queue had room");

endmodule

`default_nettype wire
